// ===== hw/rtl/pidc_pkg.sv =====
// Shared types, constants and saturation helpers for the clamped PID controller.
`timescale 1ns / 1ps

package pidc_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int OP_W      = DATA_WIDTH + 1;
  localparam int PROD_W    = 2 * OP_W;
  localparam int SUM_W     = DATA_WIDTH + 2;
  localparam int DIV_W     = DATA_WIDTH + 1 + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int CFG_IDX_W = 3;

  // smallest dt (one microsecond, rounded up) that yields a derivative
  localparam int unsigned DT_MIN_COUNT = ((1 << FRAC_BITS) + 999999) / 1000000;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [OP_W-1:0]       op_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT   = 3'd0,
    CFG_GAIN_P     = 3'd1,
    CFG_GAIN_I     = 3'd2,
    CFG_GAIN_D     = 3'd3,
    CFG_LIMIT_LOW  = 3'd4,
    CFG_LIMIT_HIGH = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_MUL_ED,
    ST_MUL_I,
    ST_MUL_P,
    ST_DIV,
    ST_MUL_D,
    ST_RES
  } pidc_state_e;

  typedef struct packed {
    logic                      start;
    logic signed [DATA_WIDTH:0] num;
    logic [DATA_WIDTH-1:0]     den;
  } div_req_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  function automatic sum_t ext_sum(input data_t v);
    ext_sum = {{(SUM_W-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
  endfunction

  function automatic op_t ext_op(input data_t v);
    ext_op = {v[DATA_WIDTH-1], v};
  endfunction

  function automatic data_t sat_sum(input sum_t v);
    logic fits;
    fits = (&v[SUM_W-1:DATA_WIDTH-1]) || !(|v[SUM_W-1:DATA_WIDTH-1]);
    sat_sum = fits ? v[DATA_WIDTH-1:0] : (v[SUM_W-1] ? DATA_MIN : DATA_MAX);
  endfunction

  // floor(p / 2^FRAC_BITS), saturated
  function automatic data_t sat_prod(input prod_t p);
    prod_t sh;
    logic  fits;
    sh   = p >>> FRAC_BITS;
    fits = (&sh[PROD_W-1:DATA_WIDTH-1]) || !(|sh[PROD_W-1:DATA_WIDTH-1]);
    sat_prod = fits ? sh[DATA_WIDTH-1:0] : (sh[PROD_W-1] ? DATA_MIN : DATA_MAX);
  endfunction

  // upper limit tested first
  function automatic data_t clamp(input data_t v, input data_t lo, input data_t hi);
    if (v > hi) begin
      clamp = hi;
    end else if (v < lo) begin
      clamp = lo;
    end else begin
      clamp = v;
    end
  endfunction

endpackage

// ===== hw/rtl/pidc_if.sv =====
// Request channels of the PID controller: sample, result and register write.
`timescale 1ns / 1ps

interface pidc_smp_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [pidc_pkg::DATA_WIDTH-1:0] measurement;
  logic [pidc_pkg::DATA_WIDTH-1:0]        dt;
  modport source (output valid, mode, measurement, dt, input ready);
  modport sink (input valid, mode, measurement, dt, output ready);
endinterface

interface pidc_res_if;
  logic                         valid;
  logic                         ready;
  logic signed [pidc_pkg::DATA_WIDTH-1:0] drive;
  modport source (output valid, drive, input ready);
  modport sink (input valid, drive, output ready);
endinterface

interface pidc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [pidc_pkg::CFG_IDX_W-1:0]       index;
  logic [pidc_pkg::DATA_WIDTH-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pidc_mul.sv =====
// Shared signed multiplier with registered product and Q-format scaling.
`timescale 1ns / 1ps

module pidc_mul (
  input  logic              clk_i,
  input  logic              en_i,
  input  pidc_pkg::op_t     a_i,
  input  pidc_pkg::op_t     b_i,
  output pidc_pkg::data_t   res_o
);

  pidc_pkg::prod_t prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= pidc_pkg::prod_t'(a_i) * pidc_pkg::prod_t'(b_i);
    end
  end

  assign res_o = pidc_pkg::sat_prod(prod_q);

endmodule

// ===== hw/rtl/pidc_div.sv =====
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den, saturated.
`timescale 1ns / 1ps

module pidc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pidc_pkg::div_req_t req_i,
  output logic               busy_o,
  output pidc_pkg::data_t    quo_o
);

  localparam int W  = pidc_pkg::DATA_WIDTH;
  localparam int DW = pidc_pkg::DIV_W;

  logic                              busy_q;
  logic [pidc_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic [DW-1:0]                     acc_q;
  logic [W-1:0]                      rem_q;
  logic [W-1:0]                      den_q;
  logic                              neg_q;

  logic [W:0]   mag;
  logic [W:0]   rem_sh;
  logic [W:0]   rem_sub;
  logic         ge;
  logic         ovf;

  assign mag     = req_i.num[W] ? (~req_i.num + 1'b1) : req_i.num;
  assign rem_sh  = {rem_q, acc_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == pidc_pkg::DIV_CNT_W'(DW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= {mag, {pidc_pkg::FRAC_BITS{1'b0}}};
      rem_q <= '0;
      den_q <= req_i.den;
      neg_q <= req_i.num[W];
    end else if (busy_q) begin
      acc_q <= {acc_q[DW-2:0], ge};
      rem_q <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
    end
  end

  always_comb begin
    if (neg_q) begin
      ovf = (|acc_q[DW-1:W]) || (acc_q[W-1] && (|acc_q[W-2:0]));
      quo_o = ovf ? pidc_pkg::DATA_MIN : (~acc_q[W-1:0] + 1'b1);
    end else begin
      ovf = |acc_q[DW-1:W-1];
      quo_o = ovf ? pidc_pkg::DATA_MAX : acc_q[W-1:0];
    end
  end

  assign busy_o = busy_q;

endmodule

// ===== hw/rtl/pid_controller_clamped.sv =====
// Top level of the clamped PID controller with sequencer and register file.
`timescale 1ns / 1ps

// Clamped PID controller, signed Q16.16. A sample request (mode 0) passes
// through ST_DISP, ST_MUL_ED, ST_MUL_I, ST_MUL_P, ST_DIV, ST_MUL_D and ST_RES,
// where its result is registered, and the sample channel is ready again in
// the cycle after: the derivative comes from a restoring divider that retires
// one quotient bit per cycle over 49 bits, while the single shared multiplier
// works through error*dt, the integral, proportional and derivative terms one
// at a time. The first sample after a restart answers with the setpoint; a
// restart request (mode 1) gives no result. A previous result still waiting
// on the result channel holds the new one back for as long as it stalls. The
// sample channel takes a new request once the previous one has its result
// registered, a restart once done; register writes are accepted every cycle.

module pid_controller_clamped (
  input  logic          clk_i,
  input  logic          rst_ni,
  pidc_cfg_if.sink      cfg_i,
  pidc_smp_if.sink      smp_i,
  pidc_res_if.source    res_o
);

  localparam int W = pidc_pkg::DATA_WIDTH;

  pidc_pkg::pidc_state_e state_q, state_d;

  pidc_pkg::data_t sp_q, kp_q, ki_q, kd_q, lo_q, hi_q;
  logic            first_q;
  pidc_pkg::data_t integ_q, last_q;
  logic            res_valid_q;

  logic            mode_q;
  pidc_pkg::data_t meas_q;
  logic [W-1:0]    dt_q;
  pidc_pkg::data_t err_q, pterm_q, drive_q;
  logic            sel_sp_q;

  logic              smp_acc, cfg_acc, res_load, mul_en;
  pidc_pkg::op_t     mul_a, mul_b;
  pidc_pkg::data_t   mul_res, div_quo, deriv, integ_new, sum_out;
  logic              div_busy;
  pidc_pkg::div_req_t div_req;

  assign smp_acc = smp_i.valid && smp_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = res_valid_q;
  assign res_o.drive = drive_q;

  assign deriv = (dt_q < W'(pidc_pkg::DT_MIN_COUNT)) ? '0 : div_quo;
  assign integ_new = (ki_q == '0) ? '0 :
      pidc_pkg::clamp(pidc_pkg::sat_sum(pidc_pkg::ext_sum(integ_q) +
                                        pidc_pkg::ext_sum(mul_res)), lo_q, hi_q);
  assign sum_out = pidc_pkg::clamp(pidc_pkg::sat_sum(pidc_pkg::ext_sum(pterm_q) +
      pidc_pkg::ext_sum(integ_q) + pidc_pkg::ext_sum(mul_res)), lo_q, hi_q);

  assign div_req.start = (state_q == pidc_pkg::ST_DISP) && !mode_q && !first_q;
  assign div_req.num   = {last_q[W-1], last_q} - {meas_q[W-1], meas_q};
  assign div_req.den   = dt_q;

  pidc_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  pidc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    smp_i.ready = 1'b0;
    mul_en      = 1'b0;
    mul_a       = pidc_pkg::ext_op(err_q);
    mul_b       = {1'b0, dt_q};
    res_load    = 1'b0;
    unique case (state_q)
      pidc_pkg::ST_IDLE: begin
        smp_i.ready = 1'b1;
        if (smp_i.valid) begin
          state_d = pidc_pkg::ST_DISP;
        end
      end
      pidc_pkg::ST_DISP: begin
        priority if (mode_q) begin
          state_d = pidc_pkg::ST_IDLE;
        end else if (first_q) begin
          state_d = pidc_pkg::ST_RES;
        end else begin
          state_d = pidc_pkg::ST_MUL_ED;
        end
      end
      pidc_pkg::ST_MUL_ED: begin
        mul_en  = 1'b1;
        state_d = pidc_pkg::ST_MUL_I;
      end
      pidc_pkg::ST_MUL_I: begin
        mul_en  = 1'b1;
        mul_a   = pidc_pkg::ext_op(ki_q);
        mul_b   = pidc_pkg::ext_op(mul_res);
        state_d = pidc_pkg::ST_MUL_P;
      end
      pidc_pkg::ST_MUL_P: begin
        mul_en  = 1'b1;
        mul_a   = pidc_pkg::ext_op(kp_q);
        mul_b   = pidc_pkg::ext_op(err_q);
        state_d = pidc_pkg::ST_DIV;
      end
      pidc_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_d = pidc_pkg::ST_MUL_D;
        end
      end
      pidc_pkg::ST_MUL_D: begin
        mul_en  = 1'b1;
        mul_a   = pidc_pkg::ext_op(kd_q);
        mul_b   = pidc_pkg::ext_op(deriv);
        state_d = pidc_pkg::ST_RES;
      end
      pidc_pkg::ST_RES: begin
        if (!res_valid_q || res_o.ready) begin
          res_load = 1'b1;
          state_d  = pidc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pidc_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      first_q     <= 1'b1;
      integ_q     <= '0;
      last_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_i.index)
          pidc_pkg::CFG_SETPOINT: begin
            sp_q    <= cfg_i.data;
            integ_q <= '0;
          end
          pidc_pkg::CFG_GAIN_P:     kp_q <= cfg_i.data;
          pidc_pkg::CFG_GAIN_I:     ki_q <= cfg_i.data;
          pidc_pkg::CFG_GAIN_D:     kd_q <= cfg_i.data;
          pidc_pkg::CFG_LIMIT_LOW:  lo_q <= cfg_i.data;
          pidc_pkg::CFG_LIMIT_HIGH: hi_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (state_q == pidc_pkg::ST_DISP) begin
        if (mode_q) begin
          first_q <= 1'b1;
          integ_q <= '0;
          last_q  <= '0;
        end else begin
          first_q <= 1'b0;
          last_q  <= meas_q;
        end
      end
      if (state_q == pidc_pkg::ST_MUL_P) begin
        integ_q <= integ_new;
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // request payload and working registers
  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      mode_q <= smp_i.mode;
      meas_q <= smp_i.measurement;
      dt_q   <= smp_i.dt;
    end
    if (state_q == pidc_pkg::ST_DISP) begin
      err_q    <= pidc_pkg::sat_sum(pidc_pkg::ext_sum(sp_q) - pidc_pkg::ext_sum(meas_q));
      sel_sp_q <= first_q;
    end
    if (state_q == pidc_pkg::ST_DIV) begin
      pterm_q <= mul_res;
    end
    if (res_load) begin
      drive_q <= sel_sp_q ? sp_q : sum_out;
    end
  end

endmodule

// ===== hw/rtl/pidc_checker.sv =====
// Port-level checks for the clamped PID controller, bound to the top level.
`timescale 1ns / 1ps

module pidc_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    smp_valid_i,
  input logic                    smp_ready_i,
  input logic                    smp_mode_i,
  input logic                    res_valid_i,
  input logic                    res_ready_i,
  input logic [pidc_pkg::DATA_WIDTH-1:0] res_drive_i
);

  logic smp_acc;
  assign smp_acc = smp_valid_i && smp_ready_i;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result request dropped while stalled");

  a_drive_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
      res_valid_i && !res_ready_i |=> $stable(res_drive_i))
    else $error("drive changed while stalled");

  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
      smp_acc |=> !smp_ready_i)
    else $error("sample taken while previous one in flight");

  a_restart_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
      smp_acc && smp_mode_i |=> !$rose(res_valid_i) ##1 !$rose(res_valid_i))
    else $error("restart produced a result");

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .smp_valid_i (smp_i.valid),
  .smp_ready_i (smp_i.ready),
  .smp_mode_i  (smp_i.mode),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_drive_i (res_o.drive)
);
